// ===== hdl/ite_pkg.sv =====
// ite_pkg: types, constants and small lookup functions for the timestamp to epoch block
// used by ite_front, ite_job_queue, ite_back and iso_timestamp_to_epoch; depends on nothing
`default_nettype none

package ite_pkg;

    // request and result items
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic signed [56:0] epoch_seconds;
        logic               valid_res;
    } out_item_t;

    // one parsed timestamp handed from the parser to the converter
    typedef struct packed {
        logic signed [31:0] year;
        logic signed [31:0] month;
        logic signed [31:0] day;
        logic signed [31:0] hour;
        logic signed [31:0] minute;
        logic signed [31:0] second;
        logic               parse_ok;
    } job_t;

    // parser scan phase
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } scan_phase_t;

    // converter sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIX,
        BK_MUL,
        BK_DAYS,
        BK_SCALE,
        BK_SUM,
        BK_OUT
    } back_state_t;

    // number fields of one timestamp
    localparam int FIELD_COUNT = 6;
    localparam logic [2:0] LAST_FIELD = 3'd5;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;

    // largest magnitude a digit run may reach (negative limit)
    localparam logic [35:0] MAG_LIMIT = 36'd2147483648;

    // calendar constants
    localparam logic [9:0]         YEARS_PER_ERA  = 10'd400;
    localparam logic [1:0]         DIV_STEPS      = 2'd2;
    // ceil(2^34 / 25): exact quotient by 25 for dividends below 2^29
    localparam logic [29:0]        ERA_RECIP      = 30'd687194768;
    localparam logic [17:0]        DAYS_PER_YEAR  = 18'd365;
    localparam logic signed [18:0] DAYS_PER_ERA   = 19'sd146097;
    localparam logic signed [20:0] DAY_OFFSET     = 21'sd719468;
    localparam logic signed [17:0] SEC_PER_DAY    = 18'sd86400;
    localparam logic signed [12:0] SEC_PER_HOUR   = 13'sd3600;
    localparam logic signed [7:0]  SEC_PER_MIN    = 8'sd60;

    // job queue
    localparam int JQ_DEPTH = 2;
    localparam int JQ_PTR_W = 1;

    // separator expected after field idx
    function automatic logic [7:0] sep_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_MINUS;
            3'd1:    c = CH_MINUS;
            3'd2:    c = CH_T;
            3'd3:    c = CH_COLON;
            3'd4:    c = CH_COLON;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // (153 * mp + 2) / 5 for shifted month mp in 0..11
    function automatic logic [8:0] doy_base(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ite_front.sv =====
// ite_front: character parser, one character per cycle unless full, builds the six
// number fields; depends on ite_pkg; hands finished strings to ite_job_queue
`default_nettype none

module ite_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ite_pkg::in_item_t item,
    input  wire logic             push,
    output logic                  full,
    output logic                  job_push,
    output ite_pkg::job_t         job,
    input  wire logic             job_full
);

    logic [2:0]           idx_reg, idx_next;
    ite_pkg::scan_phase_t phase_reg, phase_next;
    logic [31:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 failed_reg, failed_next;
    logic                 done_reg, done_next;
    logic signed [31:0]   fields_reg [ite_pkg::FIELD_COUNT];
    logic signed [31:0]   merged [ite_pkg::FIELD_COUNT];

    logic               accept;
    logic [7:0]         ch;
    logic               is_digit;
    logic               is_space;
    logic               is_sign;
    logic [3:0]         dval;
    logic [35:0]        acc;
    logic               wr_en;
    logic [2:0]         wr_idx;
    logic signed [31:0] wr_val;

    // two's complement value of a finished digit run
    function automatic logic signed [31:0] run_value(input logic [31:0] mag, input logic neg);
        return neg ? $signed(~mag + 32'd1) : $signed(mag);
    endfunction

    assign ch       = item.char_code;
    assign full     = job_full;
    assign accept   = push && !full;
    assign job_push = accept && item.last;

    // character classes
    always_comb
    begin
        is_digit = (ch >= ite_pkg::CH_0) && (ch <= ite_pkg::CH_9);
        is_space = (ch == ite_pkg::CH_SPACE) || ((ch >= ite_pkg::CH_TAB) && (ch <= ite_pkg::CH_CR));
        is_sign  = (ch == ite_pkg::CH_PLUS) || (ch == ite_pkg::CH_MINUS);
        dval     = ch[3:0];
        acc      = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + {32'b0, dval};
    end

    // scan step, then end of text on a zero character or on the last one
    always_comb
    begin
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        failed_next = failed_reg;
        done_next   = done_reg;
        wr_en       = 1'b0;
        wr_idx      = idx_reg;
        wr_val      = '0;

        if (ch != ite_pkg::CH_NUL && !done_reg && !failed_reg)
        begin
            case (phase_reg)
                ite_pkg::PH_START:
                begin
                    if (is_sign)
                    begin
                        neg_next   = (ch == ite_pkg::CH_MINUS);
                        mag_next   = '0;
                        phase_next = ite_pkg::PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        neg_next   = 1'b0;
                        mag_next   = {28'b0, dval};
                        phase_next = ite_pkg::PH_DIGITS;
                    end
                    else if (!is_space)
                    begin
                        failed_next = 1'b1;
                    end
                end
                ite_pkg::PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        mag_next   = {28'b0, dval};
                        phase_next = ite_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                    if (is_digit)
                    begin
                        if (acc > ite_pkg::MAG_LIMIT)
                            failed_next = 1'b1;
                        else
                            mag_next = acc[31:0];
                    end
                    else if (!neg_reg && mag_reg[31])
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        wr_en  = 1'b1;
                        wr_idx = idx_reg;
                        wr_val = run_value(mag_reg, neg_reg);
                        if (idx_reg >= ite_pkg::LAST_FIELD)
                        begin
                            done_next = 1'b1;
                        end
                        else if (ch == ite_pkg::sep_char(idx_reg))
                        begin
                            idx_next   = idx_reg + 3'd1;
                            phase_next = ite_pkg::PH_START;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
            endcase
        end

        if ((ch == ite_pkg::CH_NUL || item.last) && !done_next && !failed_next)
        begin
            if (phase_next != ite_pkg::PH_START && phase_next != ite_pkg::PH_SIGN &&
                idx_next >= ite_pkg::LAST_FIELD)
            begin
                if (!neg_next && mag_next[31])
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_idx    = idx_next;
                    wr_val    = run_value(mag_next, neg_next);
                    done_next = 1'b1;
                end
            end
            else
            begin
                failed_next = 1'b1;
            end
        end
    end

    // finished fields with this cycle's write folded in
    always_comb
    begin
        for (int i = 0; i < ite_pkg::FIELD_COUNT; i++)
        begin
            merged[i] = (wr_en && wr_idx == 3'(i)) ? wr_val : fields_reg[i];
        end
        job.year     = merged[0];
        job.month    = merged[1];
        job.day      = merged[2];
        job.hour     = merged[3];
        job.minute   = merged[4];
        job.second   = merged[5];
        job.parse_ok = done_next && !failed_next;
    end

    // parse state, cleared after the last character of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            phase_reg  <= ite_pkg::PH_START;
            mag_reg    <= '0;
            neg_reg    <= 1'b0;
            failed_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (item.last)
            begin
                idx_reg    <= '0;
                phase_reg  <= ite_pkg::PH_START;
                mag_reg    <= '0;
                neg_reg    <= 1'b0;
                failed_reg <= 1'b0;
                done_reg   <= 1'b0;
            end
            else
            begin
                idx_reg    <= idx_next;
                phase_reg  <= phase_next;
                mag_reg    <= mag_next;
                neg_reg    <= neg_next;
                failed_reg <= failed_next;
                done_reg   <= done_next;
            end
        end
    end

    // field store
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ite_pkg::FIELD_COUNT; i++)
        begin
            if (accept && wr_en && wr_idx == 3'(i))
                fields_reg[i] <= wr_val;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ite_job_queue.sv =====
// ite_job_queue: short queue of parsed timestamps between parser and converter
// depends on ite_pkg (job_t, queue depth)
`default_nettype none

module ite_job_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ite_pkg::job_t wr_item,
    output logic               full,
    input  wire logic          pop,
    output ite_pkg::job_t      rd_item,
    output logic               empty
);

    localparam int CNT_W = ite_pkg::JQ_PTR_W + 1;

    ite_pkg::job_t                 slots_reg [ite_pkg::JQ_DEPTH];
    logic [ite_pkg::JQ_PTR_W-1:0]  wr_ptr_reg;
    logic [ite_pkg::JQ_PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == CNT_W'(ite_pkg::JQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == ite_pkg::JQ_PTR_W'(ite_pkg::JQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == ite_pkg::JQ_PTR_W'(ite_pkg::JQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

// ===== hdl/ite_back.sv =====
// ite_back: converter sequencer, days-from-civil and scaling to seconds
// depends on ite_pkg; takes jobs from ite_job_queue, holds one result for the output side
`default_nettype none

module ite_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ite_pkg::job_t job,
    input  wire logic          job_empty,
    output logic               job_pop,
    output ite_pkg::out_item_t result,
    output logic               empty,
    input  wire logic          pop
);

    ite_pkg::back_state_t state_reg, state_next;
    logic                 out_load;
    logic                 out_valid_reg;
    ite_pkg::out_item_t   out_data_reg;

    // captured job
    logic                 ok_reg;
    logic                 yneg_reg;
    logic [3:0]           mo_reg;
    logic [4:0]           dy_reg;
    logic signed [31:0]   hr_reg, mi_reg, se_reg;

    // divide by 400
    logic [8:0]           rem_reg;
    logic [32:0]          quot_reg;
    logic [22:0]          divq_reg;
    logic [1:0]           cnt_reg;

    // staged arithmetic
    logic signed [23:0]   era_reg;
    logic [17:0]          doe_reg;
    logic signed [44:0]   hms_reg;
    logic signed [41:0]   eprod_reg;
    logic signed [41:0]   days_reg;
    logic [37:0]          plo_reg;
    logic signed [38:0]   phi_reg;
    logic signed [56:0]   sum_reg;

    // combinational helpers
    logic signed [32:0]   y_adj;
    logic [32:0]          y_mag;
    logic                 range_ok;
    logic [58:0]          div_prod;
    logic [22:0]          div_q;
    logic [32:0]          q_x400;
    logic [32:0]          y_rem;
    logic signed [23:0]   era_pos;
    logic signed [23:0]   era_fix;
    logic [8:0]           yoe;
    logic [3:0]           mp;
    logic [8:0]           doy;
    logic [1:0]           cent;
    logic [17:0]          doe_fix;
    logic signed [44:0]   hr_x, mi_x, se_x, hms_fix;
    logic signed [41:0]   eprod_fix;
    logic signed [41:0]   days_fix;
    logic [37:0]          plo_fix;
    logic signed [38:0]   phi_fix;
    logic signed [56:0]   sum_fix;

    assign result = out_data_reg;
    assign empty  = !out_valid_reg;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ite_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and handshakes
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ite_pkg::BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    state_next = ite_pkg::BK_DIV;
                end
            end
            ite_pkg::BK_DIV:
            begin
                if (cnt_reg == 2'd1)
                    state_next = ite_pkg::BK_FIX;
            end
            ite_pkg::BK_FIX:   state_next = ite_pkg::BK_MUL;
            ite_pkg::BK_MUL:   state_next = ite_pkg::BK_DAYS;
            ite_pkg::BK_DAYS:  state_next = ite_pkg::BK_SCALE;
            ite_pkg::BK_SCALE: state_next = ite_pkg::BK_SUM;
            ite_pkg::BK_SUM:   state_next = ite_pkg::BK_OUT;
            ite_pkg::BK_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = ite_pkg::BK_IDLE;
                end
            end
            default: state_next = ite_pkg::BK_IDLE;
        endcase
    end

    // year shift for january and february, magnitude for the divider, range checks
    always_comb
    begin
        y_adj = $signed({job.year[31], job.year}) -
                ((job.month <= 32'sd2) ? 33'sd1 : 33'sd0);
        y_mag = y_adj[32] ? (~y_adj + 33'd1) : y_adj;
        range_ok = job.parse_ok &&
                   (job.month >= 32'sd1) && (job.month <= 32'sd12) &&
                   (job.day >= 32'sd1) && (job.day <= 32'sd31) &&
                   (job.hour <= 32'sd23) && (job.minute <= 32'sd59) &&
                   (job.second <= 32'sd60);
    end

    // divide by 400: shift out 16, reciprocal multiply by 1/25, then remainder
    always_comb
    begin
        div_prod = 59'(quot_reg[32:4]) * 59'(ite_pkg::ERA_RECIP);
        div_q    = div_prod[56:34];
        q_x400   = ({10'b0, divq_reg} << 8) + ({10'b0, divq_reg} << 7) +
                   ({10'b0, divq_reg} << 4);
        y_rem    = quot_reg - q_x400;
    end

    // floor era and year of era, day of era, time of day
    always_comb
    begin
        era_pos = $signed({1'b0, quot_reg[22:0]});
        if (!yneg_reg)
        begin
            era_fix = era_pos;
            yoe     = rem_reg;
        end
        else if (rem_reg == 9'd0)
        begin
            era_fix = -era_pos;
            yoe     = 9'd0;
        end
        else
        begin
            era_fix = -(era_pos + 24'sd1);
            yoe     = ite_pkg::YEARS_PER_ERA[8:0] - rem_reg;
        end

        mp  = (mo_reg > 4'd2) ? (mo_reg - 4'd3) : (mo_reg + 4'd9);
        doy = ite_pkg::doy_base(mp) + {4'b0, dy_reg} - 9'd1;

        if (yoe >= 9'd300)
            cent = 2'd3;
        else if (yoe >= 9'd200)
            cent = 2'd2;
        else if (yoe >= 9'd100)
            cent = 2'd1;
        else
            cent = 2'd0;

        doe_fix = ({9'b0, yoe} * ite_pkg::DAYS_PER_YEAR) + {11'b0, yoe[8:2]} -
                  {16'b0, cent} + {9'b0, doy};

        hr_x    = 45'(hr_reg);
        mi_x    = 45'(mi_reg);
        se_x    = 45'(se_reg);
        hms_fix = (hr_x * 45'(ite_pkg::SEC_PER_HOUR)) + (mi_x * 45'(ite_pkg::SEC_PER_MIN)) +
                  se_x;
    end

    // day count and seconds, split into two partial products
    always_comb
    begin
        eprod_fix = 42'(era_reg) * 42'(ite_pkg::DAYS_PER_ERA);
        days_fix  = eprod_reg + $signed({24'b0, doe_reg}) - 42'(ite_pkg::DAY_OFFSET);
        plo_fix   = 38'(days_reg[20:0]) * 38'(ite_pkg::SEC_PER_DAY[16:0]);
        phi_fix   = 39'($signed(days_reg[41:21])) * 39'(ite_pkg::SEC_PER_DAY);
        sum_fix   = $signed({phi_reg[35:0], 21'b0}) + $signed({19'b0, plo_reg}) +
                    $signed({{12{hms_reg[44]}}, hms_reg});
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ite_pkg::BK_IDLE:
            begin
                ok_reg   <= range_ok;
                yneg_reg <= y_adj[32];
                mo_reg   <= job.month[3:0];
                dy_reg   <= job.day[4:0];
                hr_reg   <= job.hour;
                mi_reg   <= job.minute;
                se_reg   <= job.second;
                rem_reg  <= '0;
                quot_reg <= y_mag;
                cnt_reg  <= ite_pkg::DIV_STEPS;
            end
            ite_pkg::BK_DIV:
            begin
                // quotient first, then remainder and era magnitude
                if (cnt_reg == ite_pkg::DIV_STEPS)
                begin
                    divq_reg <= div_q;
                end
                else
                begin
                    rem_reg  <= y_rem[8:0];
                    quot_reg <= {10'b0, divq_reg};
                end
                cnt_reg <= cnt_reg - 2'd1;
            end
            ite_pkg::BK_FIX:
            begin
                era_reg <= era_fix;
                doe_reg <= doe_fix;
                hms_reg <= hms_fix;
            end
            ite_pkg::BK_MUL:   eprod_reg <= eprod_fix;
            ite_pkg::BK_DAYS:  days_reg  <= days_fix;
            ite_pkg::BK_SCALE:
            begin
                plo_reg <= plo_fix;
                phi_reg <= phi_fix;
            end
            ite_pkg::BK_SUM:   sum_reg <= ok_reg ? sum_fix : '0;
            default:           ;
        endcase
    end

    // output holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.epoch_seconds <= sum_reg;
            out_data_reg.valid_res     <= ok_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/iso_timestamp_to_epoch.sv =====
// iso_timestamp_to_epoch: text timestamp Y-M-DTh:m:s to Unix epoch seconds
// depends on ite_pkg, ite_front, ite_job_queue, ite_back
//
// Requests are characters of the timestamp, one per request, on item with push/full;
// a request is taken at a clock edge with push high and full low. item.last marks the
// final character of a string; a zero character ends the text early.
// Every string gives exactly one result on result with empty/pop: epoch_seconds and
// valid_res, or 0 with valid_res low when parsing or the range checks fail.
// The parser takes one character per cycle while full is low. A finished string
// waits in a two-entry queue for the converter, which works on one string at a time:
// it takes the job, divides the year by 400 with a reciprocal multiply, and runs six
// arithmetic and output stages. A result passes through the queue, the converter's
// states and the output register before it reaches the result port.
// full rises only while two strings wait for conversion, so long strings pass
// without stalls; shorter ones are throttled to the converter's pace.
// When the receiver does not pop, the result holds on the port, the converter waits,
// the queue fills and full then stops further requests.
// Reset clears the parser state, the queue and the result valid flag; empty is high after it.
`default_nettype none

module iso_timestamp_to_epoch (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ite_pkg::in_item_t  item,
    input  wire logic               push,
    output logic                    full,
    output ite_pkg::out_item_t      result,
    output logic                    empty,
    input  wire logic               pop
);

    logic          job_push;
    logic          job_full;
    logic          job_pop;
    logic          job_empty;
    ite_pkg::job_t job_wr;
    ite_pkg::job_t job_rd;

    // parser
    ite_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .job_push (job_push),
        .job      (job_wr),
        .job_full (job_full)
    );

    // queue between parser and converter
    ite_job_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wr_item (job_wr),
        .full    (job_full),
        .pop     (job_pop),
        .rd_item (job_rd),
        .empty   (job_empty)
    );

    // converter
    ite_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_rd),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // converter only takes a job that is there
    a_job_pop: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_empty)
        else $error("converter popped an empty job queue");

    // parser never pushes into a full queue
    a_job_push: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("parser pushed into a full job queue");

    // an invalid result carries zero seconds
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.valid_res) |-> (result.epoch_seconds == '0))
        else $error("invalid result with nonzero epoch seconds");

endmodule

`default_nettype wire
